// ----- sv/rfifo_pkg.sv -----
`timescale 1ns / 1ps
// rfifo_pkg: shared types and constants for the ring fifo with peek offset
// no dependencies; used by ring_fifo_with_peek_offset

package rfifo_pkg;

    // default storage geometry
    localparam int DEPTH_DEFAULT      = 256;
    localparam int DATA_WIDTH_DEFAULT = 32;

    // fixed field widths of the transfer payloads
    localparam int ACTION_W = 2;
    localparam int VALUE_W  = 32;
    localparam int OFFSET_W = 8;
    localparam int STATUS_W = 2;
    localparam int CNT_W    = 9;

    // configuration port
    localparam int PADDR_W = 3;
    localparam int PDATA_W = 32;

    // register index taken from paddr[2]
    localparam logic REG_CAPACITY = 1'b0;

    // capacity after reset and its lower clamp
    localparam logic [CNT_W-1:0] CAPACITY_RESET = 9'd256;
    localparam logic [CNT_W-1:0] CAPACITY_MIN   = 9'd2;

    // action codes
    typedef enum logic [ACTION_W-1:0] {
        ACT_INSERT = 2'd0,
        ACT_REMOVE = 2'd1,
        ACT_PEEK   = 2'd2,
        ACT_STATUS = 2'd3
    } action_t;

    // status codes
    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_OVER  = 2'd1,
        ST_UNDER = 2'd2
    } status_t;

    // one input item
    typedef struct packed {
        logic [ACTION_W-1:0] action;
        logic [VALUE_W-1:0]  value;
        logic [OFFSET_W-1:0] offset;
    } item_t;

    // one result item
    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [VALUE_W-1:0]  data;
        logic [CNT_W-1:0]    count;
        logic [CNT_W-1:0]    free_slots;
        logic                empty_res;
    } result_t;

endpackage

// ----- sv/ring_fifo_with_peek_offset.sv -----
`timescale 1ns / 1ps
// ring_fifo_with_peek_offset: circular fifo with insert, remove, peek and status
// depends on rfifo_pkg

// A command is taken on any cycle with start high; busy never rises, so one
// command can be issued every clock. Each command gives exactly one result in
// the next cycle, marked by done for a single cycle; the receiver cannot stall it.
// The data word comes from the registered read port of the entry memory.
// Writing the capacity register empties the queue; a capacity below 2
// acts as 2 and one above DEPTH acts as DEPTH.

module ring_fifo_with_peek_offset #(
    parameter int DEPTH      = rfifo_pkg::DEPTH_DEFAULT,
    parameter int DATA_WIDTH = rfifo_pkg::DATA_WIDTH_DEFAULT
) (
    input  logic                            clk,
    input  logic                            rst_n,
    // command channel
    input  logic                            start,
    input  rfifo_pkg::item_t                item,
    output logic                            busy,
    output logic                            done,
    output rfifo_pkg::result_t              result,
    // configuration port
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [rfifo_pkg::PADDR_W-1:0]   paddr,
    input  logic [rfifo_pkg::PDATA_W-1:0]   pwdata,
    output logic [rfifo_pkg::PDATA_W-1:0]   prdata,
    output logic                            pready
);

    localparam int CNT_W  = rfifo_pkg::CNT_W;
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    // wide enough for an index plus an offset and for the capacity
    localparam int CMP_W  = (ADDR_W + 1 > CNT_W + 1) ? ADDR_W + 1 : CNT_W + 1;
    localparam int DW_EXT = (DATA_WIDTH > rfifo_pkg::VALUE_W) ? DATA_WIDTH
                                                               : rfifo_pkg::VALUE_W;
    // largest capacity that the storage can back
    localparam logic [CNT_W-1:0] DEPTH_CAP =
        CNT_W'((DEPTH > (1 << CNT_W) - 1) ? (1 << CNT_W) - 1 : DEPTH);
    localparam logic [CNT_W-1:0] CAP_EFF_RESET =
        (rfifo_pkg::CAPACITY_RESET > DEPTH_CAP) ? DEPTH_CAP : rfifo_pkg::CAPACITY_RESET;

    // state registers
    logic [CNT_W-1:0]  capacity_reg, capacity_next;
    logic [CNT_W-1:0]  cap_eff_reg, cap_eff_next;
    logic [ADDR_W-1:0] rd_idx_reg, rd_idx_next;
    logic [ADDR_W-1:0] wr_idx_reg, wr_idx_next;
    logic [CNT_W-1:0]  count_reg, count_next;

    // result registers
    logic                          done_reg;
    logic [rfifo_pkg::STATUS_W-1:0] status_reg, status_next;
    logic [CNT_W-1:0]              res_count_reg;
    logic [CNT_W-1:0]              res_free_reg;
    logic                          rd_ok_reg, rd_ok_next;

    // entry memory
    logic [DATA_WIDTH-1:0] mem [DEPTH];
    logic [DATA_WIDTH-1:0] mem_q_reg;
    logic                  wr_en;
    logic                  rd_en;
    logic [ADDR_W-1:0]     rd_addr;

    logic                  accept;
    logic                  cfg_wr;
    logic [CNT_W-1:0]      cfg_cap;
    logic [CMP_W-1:0]      rd_inc;
    logic [CMP_W-1:0]      wr_inc;
    logic [CMP_W-1:0]      peek_sum;
    logic [CMP_W-1:0]      cap_ext;
    logic [DW_EXT-1:0]     data_ext;

    // command and register transfers
    assign busy   = 1'b0;
    assign pready = 1'b1;
    assign accept = start && !busy;
    assign cfg_wr = psel && penable && pwrite && pready
                    && (paddr[2] == rfifo_pkg::REG_CAPACITY);
    assign cfg_cap = pwdata[CNT_W-1:0];

    // register readback
    always_comb
    begin
        prdata = '0;
        if (paddr[2] == rfifo_pkg::REG_CAPACITY)
        begin
            prdata = rfifo_pkg::PDATA_W'(capacity_reg);
        end
    end

    // clamp capacity when it is written
    always_comb
    begin
        capacity_next = capacity_reg;
        cap_eff_next  = cap_eff_reg;
        if (cfg_wr)
        begin
            capacity_next = cfg_cap;
            if (cfg_cap < rfifo_pkg::CAPACITY_MIN)
            begin
                cap_eff_next = rfifo_pkg::CAPACITY_MIN;
            end
            else if (cfg_cap > DEPTH_CAP)
            begin
                cap_eff_next = DEPTH_CAP;
            end
            else
            begin
                cap_eff_next = cfg_cap;
            end
        end
    end

    // index arithmetic with wrap at the capacity
    assign cap_ext  = CMP_W'(cap_eff_reg);
    assign rd_inc   = CMP_W'(rd_idx_reg) + CMP_W'(1);
    assign wr_inc   = CMP_W'(wr_idx_reg) + CMP_W'(1);
    assign peek_sum = CMP_W'(rd_idx_reg) + CMP_W'(item.offset);

    // command decode and next state
    always_comb
    begin
        rd_idx_next = rd_idx_reg;
        wr_idx_next = wr_idx_reg;
        count_next  = count_reg;
        status_next = rfifo_pkg::ST_OK;
        rd_ok_next  = 1'b0;
        wr_en       = 1'b0;
        rd_en       = 1'b0;
        rd_addr     = rd_idx_reg;
        if (cfg_wr)
        begin
            rd_idx_next = '0;
            wr_idx_next = '0;
            count_next  = '0;
        end
        else if (accept)
        begin
            unique case (item.action)
                rfifo_pkg::ACT_INSERT:
                begin
                    if (count_reg >= cap_eff_reg)
                    begin
                        status_next = rfifo_pkg::ST_OVER;
                    end
                    else
                    begin
                        wr_en       = 1'b1;
                        wr_idx_next = (wr_inc >= cap_ext) ? '0 : wr_inc[ADDR_W-1:0];
                        count_next  = count_reg + CNT_W'(1);
                    end
                end
                rfifo_pkg::ACT_REMOVE:
                begin
                    if (count_reg == '0)
                    begin
                        status_next = rfifo_pkg::ST_UNDER;
                    end
                    else
                    begin
                        rd_en       = 1'b1;
                        rd_ok_next  = 1'b1;
                        rd_idx_next = (rd_inc >= cap_ext) ? '0 : rd_inc[ADDR_W-1:0];
                        count_next  = count_reg - CNT_W'(1);
                    end
                end
                rfifo_pkg::ACT_PEEK:
                begin
                    if (CNT_W'(item.offset) >= count_reg)
                    begin
                        status_next = rfifo_pkg::ST_UNDER;
                    end
                    else
                    begin
                        rd_en      = 1'b1;
                        rd_ok_next = 1'b1;
                        if (peek_sum >= cap_ext)
                        begin
                            rd_addr = ADDR_W'(peek_sum - cap_ext);
                        end
                        else
                        begin
                            rd_addr = peek_sum[ADDR_W-1:0];
                        end
                    end
                end
                default:
                begin
                    status_next = rfifo_pkg::ST_OK;
                end
            endcase
        end
    end

    // control and result registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            capacity_reg  <= rfifo_pkg::CAPACITY_RESET;
            cap_eff_reg   <= CAP_EFF_RESET;
            rd_idx_reg    <= '0;
            wr_idx_reg    <= '0;
            count_reg     <= '0;
            done_reg      <= 1'b0;
            rd_ok_reg     <= 1'b0;
        end
        else
        begin
            capacity_reg  <= capacity_next;
            cap_eff_reg   <= cap_eff_next;
            rd_idx_reg    <= rd_idx_next;
            wr_idx_reg    <= wr_idx_next;
            count_reg     <= count_next;
            done_reg      <= accept;
            rd_ok_reg     <= rd_ok_next;
        end
    end

    // result payload, no reset needed
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            status_reg    <= status_next;
            res_count_reg <= count_next;
            res_free_reg  <= cap_eff_reg - count_next;
        end
    end

    // entry memory write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_idx_reg] <= DATA_WIDTH'(item.value);
        end
    end

    // entry memory registered read port
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            mem_q_reg <= mem[rd_addr];
        end
    end

    // result outputs
    assign data_ext          = DW_EXT'(mem_q_reg);
    assign done              = done_reg;
    assign result.status     = status_reg;
    assign result.data       = rd_ok_reg ? data_ext[rfifo_pkg::VALUE_W-1:0] : '0;
    assign result.count      = res_count_reg;
    assign result.free_slots = res_free_reg;
    assign result.empty_res  = (res_count_reg == '0);

    // every accepted command yields a result on the next cycle
    a_done_follows: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> done)
        else $error("accepted command gave no result");

    // no result without a command
    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        !accept |=> !done)
        else $error("result without a command");

    // the fill never exceeds the usable capacity and indices stay inside it
    a_bounds: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg <= cap_eff_reg) && (CMP_W'(rd_idx_reg) < cap_ext)
        && (CMP_W'(wr_idx_reg) < cap_ext))
        else $error("fill or index beyond capacity");

    // a failed command never returns a data word
    a_fail_no_data: assert property (@(posedge clk) disable iff (!rst_n)
        (done && (result.status != rfifo_pkg::ST_OK)) |-> (result.data == '0))
        else $error("data returned with error status");

endmodule
